### sv/lsra_pkg.sv
// ----------------------------------------------------------------------------
// lsra_pkg: shared types and constants of the linear scan register allocator
// Slot table sizing, field widths, stream packing and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lsra_pkg;

  localparam int NUM_REGS      = 12;
  localparam int POSITION_BITS = 16;
  localparam int ID_BITS       = 10;

  localparam int SLOT_BITS  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int COUNT_BITS = $clog2(NUM_REGS + 1);
  localparam int REG_BITS   = 4;   // assigned_reg field width
  localparam int CFG_BITS   = 4;   // regs_in_use register width

  localparam logic [CFG_BITS-1:0] REGS_IN_USE_RESET = CFG_BITS'(12);

  // Stream packing
  localparam int IN_FIELD_BITS  = ID_BITS + 2 * POSITION_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = REG_BITS + ID_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Input op codes
  localparam logic OP_NEW_PASS = 1'b0;
  localparam logic OP_ALLOC    = 1'b1;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [ID_BITS-1:0]       id_t;
  typedef logic [SLOT_BITS-1:0]     slot_t;
  typedef logic [COUNT_BITS-1:0]    count_t;

  // Table write command
  typedef struct packed {
    logic  clear;    // new pass: drop every slot
    logic  apply;    // allocation item: commit expiry
    logic  set;      // write slot with new interval
    slot_t slot;
    pos_t  end_pos;
    id_t   owner;
  } slot_wr_t;

  // Allocation decision
  typedef struct packed {
    logic  got;      // interval received a register
    logic  evict;    // it took the register of the victim
    slot_t slot;     // register taken (free or victim)
  } decision_t;

endpackage

`default_nettype wire

### sv/lsra_slot_table.sv
// ----------------------------------------------------------------------------
// lsra_slot_table: per-register busy flags, interval ends and owner ids
// Computes which slots are still live at the new start and commits updates.
// ----------------------------------------------------------------------------
`default_nettype none

module lsra_slot_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lsra_pkg::pos_t                      start_pos,
  input  wire lsra_pkg::slot_wr_t                  wr,
  input  wire lsra_pkg::slot_t                     rd_slot,
  output lsra_pkg::pos_t                           slot_end [lsra_pkg::NUM_REGS],
  output logic [lsra_pkg::NUM_REGS-1:0]            live,
  output lsra_pkg::id_t                            rd_owner
);

  logic [lsra_pkg::NUM_REGS-1:0] busy;
  logic [lsra_pkg::NUM_REGS-1:0] busy_next;
  lsra_pkg::id_t                 slot_owner [lsra_pkg::NUM_REGS];

  // A slot stays live while its end is not below the new start.
  always_comb begin
    for (int i = 0; i < lsra_pkg::NUM_REGS; i++) begin
      live[i] = busy[i] && !(slot_end[i] < start_pos);
    end
  end

  always_comb begin
    busy_next = busy;
    if (wr.clear) begin
      busy_next = '0;
    end else if (wr.apply) begin
      busy_next = live;
      if (wr.set) begin
        busy_next[wr.slot] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      busy <= busy_next;
    end
  end

  // Ends and owners are only read behind a busy flag; no reset needed.
  always_ff @(posedge clk) begin
    if (wr.apply && wr.set) begin
      slot_end[wr.slot]   <= wr.end_pos;
      slot_owner[wr.slot] <= wr.owner;
    end
  end

  assign rd_owner = slot_owner[rd_slot];

endmodule

`default_nettype wire

### sv/lsra_select.sv
// ----------------------------------------------------------------------------
// lsra_select: allocation decision for one interval, or a spill
// Lowest free usable slot, else max-end victim past new_end (ties to lowest).
// ----------------------------------------------------------------------------
`default_nettype none

module lsra_select (
  input  wire logic [lsra_pkg::NUM_REGS-1:0] live,
  input  wire lsra_pkg::pos_t                slot_end [lsra_pkg::NUM_REGS],
  input  wire lsra_pkg::count_t              usable_n,
  input  wire lsra_pkg::pos_t                new_end,
  output lsra_pkg::decision_t                dec
);

  localparam int LEVELS = (lsra_pkg::NUM_REGS > 1) ? $clog2(lsra_pkg::NUM_REGS) : 1;
  localparam int TREE_N = 1 << LEVELS;

  logic [lsra_pkg::NUM_REGS-1:0] usable;
  logic                          any_free;
  lsra_pkg::slot_t               free_slot;

  logic            cand_v [TREE_N];
  lsra_pkg::pos_t  cand_e [TREE_N];
  lsra_pkg::slot_t cand_i [TREE_N];

  always_comb begin
    for (int i = 0; i < lsra_pkg::NUM_REGS; i++) begin
      usable[i] = lsra_pkg::COUNT_BITS'(i) < usable_n;
    end
  end

  // Priority encoder, lowest index wins
  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int i = lsra_pkg::NUM_REGS - 1; i >= 0; i--) begin
      if (usable[i] && !live[i]) begin
        any_free  = 1'b1;
        free_slot = lsra_pkg::SLOT_BITS'(i);
      end
    end
  end

  // Max-end tree; the left (lower) entry wins on equal ends.
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      if (i < lsra_pkg::NUM_REGS) begin
        cand_v[i] = usable[i] && live[i];
        cand_e[i] = slot_end[i];
      end else begin
        cand_v[i] = 1'b0;
        cand_e[i] = '0;
      end
      cand_i[i] = lsra_pkg::SLOT_BITS'(i);
    end
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      for (int j = 0; j < TREE_N; j += (2 << lvl)) begin
        if (cand_v[j + (1 << lvl)] &&
            (!cand_v[j] || (cand_e[j + (1 << lvl)] > cand_e[j]))) begin
          cand_v[j] = 1'b1;
          cand_e[j] = cand_e[j + (1 << lvl)];
          cand_i[j] = cand_i[j + (1 << lvl)];
        end
      end
    end
  end

  always_comb begin
    dec = '0;
    if (any_free) begin
      dec.got  = 1'b1;
      dec.slot = free_slot;
    end else if (cand_v[0] && (cand_e[0] > new_end)) begin
      dec.got   = 1'b1;
      dec.evict = 1'b1;
      dec.slot  = cand_i[0];
    end
  end

endmodule

`default_nettype wire

### sv/linear_scan_register_allocator_unit.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_unit: linear scan register allocation
// One result item per input item: assigned register, eviction or spill, or all zero for a new pass.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register and moves into the result register once that one is empty or taken.
// Throughput: one item per cycle while m_tready stays high; expiry, selection and table update all
//   happen between the input register and the result register.
// Reset (rst, synchronous): empties the slot table, drops both pipeline
//   registers and sets regs_in_use to 12. No clearing pass is needed.
`default_nettype none

module linear_scan_register_allocator_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // config: regs_in_use
  input  wire logic                                 cfg_we,
  input  wire logic [lsra_pkg::CFG_BITS-1:0]        cfg_wdata,
  // input items
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // tdata, low bit up: id, start pos, end pos, zero pad
  input  wire logic [lsra_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // tuser: op
  input  wire logic                                 s_tuser,
  // result items
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // tdata, low bit up: assigned_reg, evicted_id, zero pad
  output logic [lsra_pkg::OUT_DATA_BITS-1:0]        m_tdata,
  // tuser, low bit up: got_register, evicted_valid
  output logic [1:0]                                m_tuser
);

  localparam int START_LSB = lsra_pkg::ID_BITS;
  localparam int END_LSB   = lsra_pkg::ID_BITS + lsra_pkg::POSITION_BITS;

  // Config register
  logic [lsra_pkg::CFG_BITS-1:0] regs_in_use;
  lsra_pkg::count_t              usable_n;

  // Input register
  logic            in_valid;
  logic            in_op;
  lsra_pkg::id_t   in_id;
  lsra_pkg::pos_t  in_start;
  lsra_pkg::pos_t  in_end;

  logic                  adv;       // input register moves into result register
  logic                  s_accept;
  logic                  work;      // an item is being processed this cycle
  lsra_pkg::slot_wr_t    wr;
  lsra_pkg::decision_t   dec;
  lsra_pkg::pos_t        slot_end [lsra_pkg::NUM_REGS];
  logic [lsra_pkg::NUM_REGS-1:0] live;
  lsra_pkg::id_t         victim_owner;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_in_use <= lsra_pkg::REGS_IN_USE_RESET;
    end else if (cfg_we) begin
      regs_in_use <= cfg_wdata;
    end
  end

  // Zero acts as one, anything above the table size as the table size.
  always_comb begin
    if (regs_in_use == '0) begin
      usable_n = lsra_pkg::COUNT_BITS'(1);
    end else if ({1'b0, regs_in_use} > (lsra_pkg::CFG_BITS + 1)'(lsra_pkg::NUM_REGS)) begin
      usable_n = lsra_pkg::COUNT_BITS'(lsra_pkg::NUM_REGS);
    end else begin
      usable_n = lsra_pkg::COUNT_BITS'(regs_in_use);
    end
  end

  // Handshake: the result register parts the two sides.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;
  assign s_accept = s_tvalid && s_tready;
  assign work     = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_op    <= s_tuser;
      in_id    <= s_tdata[lsra_pkg::ID_BITS-1:0];
      in_start <= s_tdata[START_LSB +: lsra_pkg::POSITION_BITS];
      in_end   <= s_tdata[END_LSB +: lsra_pkg::POSITION_BITS];
    end
  end

  lsra_slot_table u_table (
    .clk       (clk),
    .rst       (rst),
    .start_pos (in_start),
    .wr        (wr),
    .rd_slot   (dec.slot),
    .slot_end  (slot_end),
    .live      (live),
    .rd_owner  (victim_owner)
  );

  lsra_select u_select (
    .live     (live),
    .slot_end (slot_end),
    .usable_n (usable_n),
    .new_end  (in_end),
    .dec      (dec)
  );

  // Table commits in the same edge that loads the result, so the next
  // item already sees the updated slots.
  always_comb begin
    wr.clear   = work && (in_op == lsra_pkg::OP_NEW_PASS);
    wr.apply   = work && (in_op == lsra_pkg::OP_ALLOC);
    wr.set     = dec.got;
    wr.slot    = dec.slot;
    wr.end_pos = in_end;
    wr.owner   = in_id;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      if ((in_op == lsra_pkg::OP_ALLOC) && dec.got) begin
        m_tuser <= {dec.evict, 1'b1};
        m_tdata <= lsra_pkg::OUT_DATA_BITS'({
                     (dec.evict ? victim_owner : lsra_pkg::id_t'(0)),
                     lsra_pkg::REG_BITS'(dec.slot)});
      end else begin
        // new pass or spill: all fields zero
        m_tuser <= '0;
        m_tdata <= '0;
      end
    end
  end

  // An item in the input register always lands in the result register.
  a_work_lands : assert property (@(posedge clk) disable iff (rst)
    work |=> m_tvalid)
    else $error("processed item did not reach the result register");

  // An eviction always comes with a register.
  a_evict_has_reg : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tuser[0])
    else $error("eviction reported without a register");

  // Spill and new pass results carry all-zero data.
  a_spill_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
    else $error("spill result carries nonzero fields");

  // With the result register empty the block always takes an item.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result register");

endmodule

`default_nettype wire
